@@ src/assert_macros.svh @@
// Assertion macros shared by the record table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define KRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define KRT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/krt_pkg.sv @@
// Types and constants for the keyed record table.
package krt_pkg;

    // Widest name the item can carry, in bits.
    localparam int NAME_BITS_MAX = 160;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        RS_INSERTED  = 3'd0,
        RS_DUPLICATE = 3'd1,
        RS_FULL      = 3'd2,
        RS_DELETED   = 3'd3,
        RS_NOTFOUND  = 3'd4,
        RS_ENTRY     = 3'd5,
        RS_EMPTY     = 3'd6
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESULT,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    // Input item.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [63:0] name_low;
        logic [63:0] name_mid;
        logic [31:0] name_high;
        logic [7:0]  age;
    } req_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [63:0] out_name_low;
        logic [63:0] out_name_mid;
        logic [31:0] out_name_high;
        logic [7:0]  out_age;
        logic [4:0]  position;
        logic        last;
    } rsp_item_t;

    // One stored record.
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] name_low;
        logic [63:0] name_mid;
        logic [31:0] name_high;
        logic [7:0]  age;
    } rec_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic    load_req;
        logic    ptr_clr;
        logic    step;
        logic    hit_latch;
        logic    load_found;
        logic    shift_wr;
        logic    write_new;
        logic    count_dec;
        logic    out_load;
        status_t status;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic hit;
        logic scan_done;
        logic empty;
        logic full;
        logic list_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/krt_dp.sv @@
// Datapath of the record table: record memory, scan pointer, count and result register.
`include "assert_macros.svh"

module krt_dp
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BYTES  = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  logic      rsp_stall,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      rsp_valid,
    output rsp_item_t rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    rec_t            mem [TABLE_DEPTH];
    rec_t            rd_data_reg;
    rec_t            new_rec_reg;
    rec_t            new_rec_next;
    logic [CW-1:0]   ptr_reg;
    logic [CW-1:0]   ptr_next;
    logic            pend_reg;
    logic            pend_next;
    logic [AW-1:0]   pend_ptr_reg;
    logic [AW-1:0]   hit_pos_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_item_t       rsp_reg;
    rsp_item_t       rsp_next;
    logic            issue;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    rec_t            mem_wd;
    logic [NAME_BITS_MAX-1:0] name_mask;
    logic [NAME_BITS_MAX-1:0] name_kept;
    logic [AW-1:0]   pos_sel;

    // Keep only the name bytes below NAME_BYTES.
    always_comb
    begin
        for (int b = 0; b < NAME_BITS_MAX / 8; b++)
        begin
            name_mask[b*8 +: 8] = (b < NAME_BYTES) ? 8'hFF : 8'h00;
        end
        name_kept = {req.name_high, req.name_mid, req.name_low} & name_mask;
        new_rec_next.key       = req.key;
        new_rec_next.name_low  = name_kept[63:0];
        new_rec_next.name_mid  = name_kept[127:64];
        new_rec_next.name_high = name_kept[159:128];
        new_rec_next.age       = req.age;
    end

    // Status toward the controller.
    always_comb
    begin
        stat.hit       = pend_reg && (rd_data_reg.key == new_rec_reg.key);
        stat.scan_done = !pend_reg && (ptr_reg >= count_reg);
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CW'(TABLE_DEPTH));
        stat.list_last = ((CW'(pend_ptr_reg) + CW'(1)) == count_reg);
        stat.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    assign issue = cmd.step && (ptr_reg < count_reg);

    // Advance the scan pointer and the entry count.
    always_comb
    begin
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        priority if (cmd.ptr_clr)
        begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.load_found)
        begin
            ptr_next  = CW'(pend_ptr_reg) + CW'(1);
            pend_next = 1'b0;
        end
        else if (cmd.step)
        begin
            pend_next = issue;
            if (issue)
            begin
                ptr_next = ptr_reg + CW'(1);
            end
        end
        else
        begin
            // hold the pointer
            ptr_next = ptr_reg;
        end
        if (cmd.write_new)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Pick the memory write: append a new record or move one down a slot.
    always_comb
    begin
        mem_we = cmd.write_new || (cmd.shift_wr && pend_reg);
        if (cmd.write_new)
        begin
            mem_wa = count_reg[AW-1:0];
            mem_wd = new_rec_reg;
        end
        else
        begin
            mem_wa = pend_ptr_reg - AW'(1);
            mem_wd = rd_data_reg;
        end
    end

    // Build the result item from the status code.
    always_comb
    begin
        unique case (cmd.status)
            RS_INSERTED:               pos_sel = count_reg[AW-1:0];
            RS_DUPLICATE, RS_DELETED:  pos_sel = hit_pos_reg;
            RS_ENTRY:                  pos_sel = pend_ptr_reg;
            default:                   pos_sel = '0;
        endcase
        rsp_next.status        = cmd.status;
        rsp_next.position      = 5'(pos_sel);
        rsp_next.out_key       = new_rec_reg.key;
        rsp_next.out_name_low  = '0;
        rsp_next.out_name_mid  = '0;
        rsp_next.out_name_high = '0;
        rsp_next.out_age       = '0;
        rsp_next.last          = 1'b1;
        if (cmd.status == RS_ENTRY)
        begin
            rsp_next.out_key       = rd_data_reg.key;
            rsp_next.out_name_low  = rd_data_reg.name_low;
            rsp_next.out_name_mid  = rd_data_reg.name_mid;
            rsp_next.out_name_high = rd_data_reg.name_high;
            rsp_next.out_age       = rd_data_reg.age;
            rsp_next.last          = stat.list_last;
        end
        else if (cmd.status == RS_EMPTY)
        begin
            rsp_next.out_key = '0;
        end
    end

    // Hold the result until it is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            new_rec_reg <= new_rec_next;
        end
        if (issue)
        begin
            pend_ptr_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.hit_latch)
        begin
            hit_pos_reg <= pend_ptr_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Record memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `KRT_ASSERT_IMP(a_append_not_full, cmd.write_new, count_reg < CW'(TABLE_DEPTH), "append to full table")
    `KRT_ASSERT_NXT(a_count_shrinks, cmd.count_dec, count_reg == CW'($past(count_reg) - CW'(1)), "count did not shrink")
    `KRT_ASSERT_IMP(a_load_free, cmd.out_load, !rsp_valid_reg || !rsp_stall, "result overwritten")

endmodule

@@ src/krt_ctrl.sv @@
// Controller state machine of the record table.
`include "assert_macros.svh"

module krt_ctrl
    import krt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_command,
    input  dp_stat_t   stat,
    output logic       req_stall,
    output dp_cmd_t    cmd
);

    state_t  state_reg;
    state_t  state_next;
    cmd_t    op_reg;
    cmd_t    op_next;
    status_t res_reg;
    status_t res_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_INSERT;
            res_reg   <= RS_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            res_reg   <= res_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.status = res_reg;
        req_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.ptr_clr  = 1'b1;
                    priority if (req_command == CMD_INSERT)
                    begin
                        op_next    = CMD_INSERT;
                        state_next = S_SEARCH;
                    end
                    else if (req_command == CMD_DELETE)
                    begin
                        op_next    = CMD_DELETE;
                        state_next = S_SEARCH;
                    end
                    else if (req_command == CMD_LIST)
                    begin
                        op_next = CMD_LIST;
                        if (stat.empty)
                        begin
                            res_next   = RS_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    else
                    begin
                        // drop an unknown command
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEARCH:
            begin
                priority if (stat.hit)
                begin
                    cmd.hit_latch = 1'b1;
                    if (op_reg == CMD_INSERT)
                    begin
                        res_next   = RS_DUPLICATE;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.load_found = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else if (stat.scan_done)
                begin
                    if (op_reg == CMD_INSERT)
                    begin
                        res_next = stat.full ? RS_FULL : RS_INSERTED;
                    end
                    else
                    begin
                        res_next = RS_NOTFOUND;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.scan_done)
                begin
                    res_next   = RS_DELETED;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.step     = 1'b1;
                    cmd.shift_wr = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.write_new = (res_reg == RS_INSERTED);
                    cmd.count_dec = (res_reg == RS_DELETED);
                    state_next    = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                cmd.step   = 1'b1;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                cmd.status = RS_ENTRY;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `KRT_ASSERT_IMP(a_search_op, state_reg == S_SEARCH, op_reg == CMD_INSERT || op_reg == CMD_DELETE, "search without insert or delete")

endmodule

@@ src/keyed_record_table_top.sv @@
// Top level of the keyed record table: controller plus datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------
//  request | req_valid | req_stall | req (command, key, name, age)
//  result  | rsp_valid | rsp_stall | rsp (status, entry, position)
//
// Insert and delete scan one slot per cycle until a hit or the last stored record,
// then load the result. Delete then moves each later record down one slot per
// cycle through the read and write ports. List reads each record, then emits it.
// Reset clears the count and the control state only. A stalled result holds the
// output register and the controller waits on it.
module keyed_record_table_top
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BYTES  = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    krt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .stat        (stat),
        .req_stall   (req_stall),
        .cmd         (cmd)
    );

    krt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

@@ tb/krt_tb_pkg.sv @@
// Scoreboard class that predicts and checks the result items of the keyed record table.
package krt_tb_pkg;
    import krt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int NAME_BYTES  = 20;

    // Command code with no meaning: the block drops the item.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class record_table_scoreboard;
        rec_t      records[TABLE_DEPTH];
        int        entry_count;
        rsp_item_t expected_q[$];
        int        error_count;

        function new();
            entry_count = 0;
            error_count = 0;
        endfunction

        // Return the slot that holds key, or -1.
        function int find_slot(logic [31:0] key);
            for (int i = 0; i < entry_count; i++)
            begin
                if (records[i].key == key)
                    return i;
            end
            return -1;
        endfunction

        // Keep only the name bytes below NAME_BYTES.
        function logic [159:0] name_mask();
            logic [159:0] mask;
            mask = '0;
            for (int b = 0; b < 20; b++)
            begin
                if (b < NAME_BYTES)
                    mask[b*8 +: 8] = 8'hFF;
            end
            return mask;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Update the table for an accepted item and queue the results it causes.
        function void note_request(req_item_t item);
            rsp_item_t    res;
            int           slot;
            logic [159:0] name;
            res         = '0;
            res.out_key = item.key;
            res.last    = 1'b1;
            slot        = find_slot(item.key);
            case (item.command)
                CMD_INSERT:
                begin
                    if (slot >= 0)
                    begin
                        // duplicate wins over full
                        res.status   = RS_DUPLICATE;
                        res.position = slot[4:0];
                    end
                    else if (entry_count >= TABLE_DEPTH)
                        res.status = RS_FULL;
                    else
                    begin
                        name = {item.name_high, item.name_mid, item.name_low} & name_mask();
                        records[entry_count].key       = item.key;
                        records[entry_count].name_low  = name[63:0];
                        records[entry_count].name_mid  = name[127:64];
                        records[entry_count].name_high = name[159:128];
                        records[entry_count].age       = item.age;
                        res.status   = RS_INSERTED;
                        res.position = entry_count[4:0];
                        entry_count++;
                    end
                    expected_q.push_back(res);
                end
                CMD_DELETE:
                begin
                    if (slot < 0)
                        res.status = RS_NOTFOUND;
                    else
                    begin
                        // shift later records down one slot
                        for (int i = slot; i + 1 < entry_count; i++)
                            records[i] = records[i + 1];
                        entry_count--;
                        res.status   = RS_DELETED;
                        res.position = slot[4:0];
                    end
                    expected_q.push_back(res);
                end
                CMD_LIST:
                begin
                    if (entry_count == 0)
                    begin
                        res.status  = RS_EMPTY;
                        res.out_key = '0;
                        expected_q.push_back(res);
                    end
                    else
                    begin
                        for (int i = 0; i < entry_count; i++)
                        begin
                            res.status        = RS_ENTRY;
                            res.out_key       = records[i].key;
                            res.out_name_low  = records[i].name_low;
                            res.out_name_mid  = records[i].name_mid;
                            res.out_name_high = records[i].name_high;
                            res.out_age       = records[i].age;
                            res.position      = i[4:0];
                            res.last          = (i + 1 == entry_count);
                            expected_q.push_back(res);
                        end
                    end
                end
                default:
                begin
                    // unused command: no result, no change
                end
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                error_count++;
            end
        endfunction

        // Compare an accepted result item with the oldest expectation.
        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item: status %0d key %0h", got.status, got.out_key);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("out_key", 64'(want.out_key), 64'(got.out_key));
            compare_field("out_name_low", want.out_name_low, got.out_name_low);
            compare_field("out_name_mid", want.out_name_mid, got.out_name_mid);
            compare_field("out_name_high", 64'(want.out_name_high), 64'(got.out_name_high));
            compare_field("out_age", 64'(want.out_age), 64'(got.out_age));
            compare_field("position", 64'(want.position), 64'(got.position));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Testbench top: drives requests into the keyed record table and checks every result item.
module tb_top;
    import krt_pkg::*;
    import krt_tb_pkg::*;

    localparam int RANDOM_ITEMS    = 400;
    localparam int KEY_POOL        = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 80;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    record_table_scoreboard table_sb;
    bit quiet_mode       = 1'b0;
    int hold_off_request = 0;
    int requests_sent    = 0;
    int idle_cycles      = 0;

    keyed_record_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Note accepted requests and check accepted results.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            table_sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            table_sb.check_result(rsp);
    end

    // Abort when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_idle();
        if (quiet_mode)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Result side: stall a random number of cycles before each item, or hold off long.
    initial
    begin : receiver
        int stall;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                stall            = hold_off_request;
                hold_off_request = 0;
            end
            else
                stall = draw_idle();
            if (stall > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Offer one item after a random gap; return at the falling edge after acceptance.
    task automatic send_item(input req_item_t item);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        if (item.command != CMD_UNUSED)
            requests_sent++;
    endtask

    // Drop valid and hold until every expected result has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (table_sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic req_item_t make_item(logic [1:0] cmd, logic [31:0] key,
                                            logic [63:0] nl, logic [63:0] nm,
                                            logic [31:0] nh, logic [7:0] age);
        req_item_t item;
        item.command   = cmd;
        item.key       = key;
        item.name_low  = nl;
        item.name_mid  = nm;
        item.name_high = nh;
        item.age       = age;
        return item;
    endfunction

    function automatic req_item_t make_random(logic [1:0] cmd, logic [31:0] key);
        return make_item(cmd, key, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                         8'($urandom_range(0, 255)));
    endfunction

    // Pick a key: often one in the table, else from a small pool or fully random.
    function automatic logic [31:0] pick_key();
        int sel;
        int n;
        sel = $urandom_range(0, 3);
        n   = table_sb.entry_count;
        if (sel < 2 && n > 0)
            return table_sb.records[$urandom_range(0, n - 1)].key;
        if (sel < 3)
            return 32'($urandom_range(0, KEY_POOL - 1));
        return $urandom;
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] key;
        key = $urandom;
        while (table_sb.find_slot(key) >= 0)
            key = $urandom;
        return key;
    endfunction

    // Mixed traffic with noise.
    task automatic run_mixed(input int count);
        int sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_item(make_random(CMD_INSERT, pick_key()));
            else if (sel < 75)
                send_item(make_random(CMD_DELETE, pick_key()));
            else if (sel < 93)
                send_item(make_random(CMD_LIST, pick_key()));
            else
                send_item(make_random(CMD_UNUSED, $urandom));
        end
    endtask

    // Fill the table, then hit full, duplicate-in-full, a full list, middle and end deletes, refills and a list.
    task automatic run_fill(input bit hold);
        int n;
        if (hold)
            hold_off_request = HOLD_OFF_CYCLES;
        while (table_sb.entry_count < TABLE_DEPTH)
            send_item(make_random(CMD_INSERT, fresh_key()));
        send_item(make_random(CMD_INSERT, fresh_key()));
        n = $urandom_range(0, TABLE_DEPTH - 1);
        send_item(make_random(CMD_INSERT, table_sb.records[n].key));
        send_item(make_random(CMD_LIST, $urandom));
        n = $urandom_range(1, TABLE_DEPTH - 2);
        send_item(make_random(CMD_DELETE, table_sb.records[n].key));
        send_item(make_random(CMD_DELETE, table_sb.records[table_sb.entry_count - 1].key));
        send_item(make_random(CMD_DELETE, table_sb.records[0].key));
        repeat (4)
            send_item(make_random(CMD_INSERT, fresh_key()));
        send_item(make_random(CMD_LIST, $urandom));
    endtask

    // Delete until empty, with misses and lists mixed in.
    task automatic run_drain();
        int sel;
        while (table_sb.entry_count > 0)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                send_item(make_random(CMD_DELETE, fresh_key()));
            else if (sel == 1)
                send_item(make_random(CMD_LIST, $urandom));
            else
                send_item(make_random(CMD_DELETE,
                    table_sb.records[$urandom_range(0, table_sb.entry_count - 1)].key));
        end
        send_item(make_random(CMD_LIST, $urandom));
    endtask

    initial
    begin : stimulus
        int phase;
        table_sb  = new();
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, field extremes, duplicate, middle, last-slot and first-slot delete.
        send_item(make_item(CMD_LIST, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_DELETE, 32'd5, '0, '0, '0, '0));
        send_item(make_item(CMD_INSERT, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_INSERT, '1, '1, '1, '1, '1));
        send_item(make_item(CMD_INSERT, '0, '1, '1, '1, '1));
        send_item(make_item(CMD_INSERT, 32'h1234_5678, {16{4'hA}}, {16{4'h5}}, 32'hAAAA_AAAA,
                            8'h55));
        send_item(make_item(CMD_LIST, '1, '1, '1, '1, '1));
        send_item(make_item(CMD_UNUSED, '1, '1, '1, '1, '1));
        send_item(make_item(CMD_DELETE, '1, '0, '0, '0, '0));
        send_item(make_item(CMD_LIST, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_DELETE, 32'h1234_5678, '0, '0, '0, '0));
        send_item(make_item(CMD_DELETE, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_DELETE, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_LIST, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_INSERT, 32'h8000_0001, {16{4'h5}}, {16{4'hA}}, 32'h5555_5555,
                            8'hAA));
        send_item(make_item(CMD_LIST, '0, '0, '0, '0, '0));
        wait_drained();

        // Random phases; some run with no idling on either side.
        requests_sent = 0;
        phase         = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            quiet_mode = ($urandom_range(0, 3) == 0);
            case (phase % 4)
                0: run_mixed(30);
                1: run_fill(phase == 1);
                2: run_mixed(20);
                default: run_drain();
            endcase
            if (phase == 0 || $urandom_range(0, 2) == 0)
                wait_drained();
            phase++;
        end

        // Let the last results come out, then report.
        req_valid <= 1'b0;
        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/krt_pkg.sv
src/krt_dp.sv
src/krt_ctrl.sv
src/keyed_record_table_top.sv
tb/krt_tb_pkg.sv
tb/tb_top.sv
